[design/kbf_pkg.sv]
// ----------------------------------------------------------------------------
// kbf_pkg
// Shared types, codes and fixed-point helpers of the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package kbf_pkg;

    localparam logic [1:0] CFG_PROC_NOISE = 2'd0;
    localparam logic [1:0] CFG_MEAS_NOISE = 2'd1;
    localparam logic [1:0] CFG_YAW_DBAND  = 2'd2;

    localparam logic [19:0] PROC_NOISE_RST = 20'd5243;
    localparam logic [19:0] MEAS_NOISE_RST = 20'd32768;
    localparam logic [19:0] YAW_DBAND_RST  = 20'd5243;

    localparam int unsigned DIV_STEPS = 60;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_PRED,
        MUL_P11,
        MUL_Q,
        MUL_S,
        MUL_K0I,
        MUL_K1I,
        MUL_K0N00,
        MUL_K0N01,
        MUL_K1N00,
        MUL_K1N01,
        MUL_YAW
    } t_mul;

    typedef enum logic [3:0] {
        WR_NONE,
        WR_PRED,
        WR_P11,
        WR_N11,
        WR_N00,
        WR_K0,
        WR_K1,
        WR_KZERO,
        WR_ANG,
        WR_BIAS,
        WR_P0,
        WR_P1,
        WR_P2,
        WR_P3,
        WR_YAW
    } t_wr;

    typedef struct packed {
        t_mul mul;
        t_wr  wr;
        logic innov_we;
        logic div_start;
        logic div_sel;
        logic capture;
        logic load_out;
        logic axis;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic denom_pos;
    } t_sts;

    // floor((x + 2^(s-1)) / 2^s)
    function automatic logic signed [71:0] rshr(input logic signed [71:0] x,
                                                input int unsigned s);
        return (x + (72'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        if (x > 72'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -72'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(x);
    endfunction

endpackage

[design/kbf_div.sv]
// ----------------------------------------------------------------------------
// kbf_div
// Restoring divider, one quotient bit per cycle: sat32(num * 2^28 / den).
// ----------------------------------------------------------------------------
module kbf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_num,
    input  logic [32:0]         i_den,
    output logic                o_done,
    output logic signed [31:0]  o_quot
);
    import kbf_pkg::*;

    logic [32:0] r_rem;
    logic [59:0] r_quo;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic        r_neg;

    logic [33:0] w_trial;
    logic        w_ge;
    logic [31:0] w_mag;
    logic signed [71:0] w_q;

    assign w_trial = {r_rem, r_quo[59]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_mag   = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_q     = r_neg ? -$signed({12'd0, r_quo}) : $signed({12'd0, r_quo});
    assign o_quot  = sat32(w_q);
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_STEPS);
                r_rem  <= '0;
                r_quo  <= {w_mag, 28'd0};
                r_den  <= i_den;
                r_neg  <= i_num[31];
            end else if (r_busy) begin
                r_rem  <= w_ge ? 33'(w_trial - {1'b0, r_den}) : w_trial[32:0];
                r_quo  <= {r_quo[58:0], w_ge};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    property p_done_once;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |=> !r_done;
    endproperty
    a_done_once: assert property (p_done_once) else $error("divider done held");

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(r_done) |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("done without run");

    property p_no_restart;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !i_start;
    endproperty
    a_no_restart: assert property (p_no_restart) else $error("start while busy");

endmodule

[design/kbf_datapath.sv]
// ----------------------------------------------------------------------------
// kbf_datapath
// Filter state, shared multiplier, divider and result register.
// ----------------------------------------------------------------------------
module kbf_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kbf_pkg::t_cmd       i_cmd,
    output kbf_pkg::t_sts       o_sts,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [19:0]         i_cfg_data,
    input  logic signed [24:0]  i_roll_meas,
    input  logic signed [24:0]  i_pitch_meas,
    input  logic signed [27:0]  i_roll_rate,
    input  logic signed [27:0]  i_pitch_rate,
    input  logic signed [27:0]  i_yaw_rate_in,
    input  logic [15:0]         i_time_step,
    output logic signed [31:0]  o_roll_angle,
    output logic signed [31:0]  o_roll_bias,
    output logic signed [31:0]  o_pitch_angle,
    output logic signed [31:0]  o_pitch_bias,
    output logic signed [31:0]  o_yaw_angle,
    output logic signed [27:0]  o_yaw_rate_out
);
    import kbf_pkg::*;

    logic [19:0] r_pn, r_rn, r_db;
    logic signed [24:0] r_meas [2];
    logic signed [27:0] r_rate [2];
    logic signed [27:0] r_yr;
    logic [15:0]        r_dt;
    logic signed [31:0] r_ang  [2];
    logic signed [31:0] r_bias [2];
    logic signed [31:0] r_p    [2][4];
    logic signed [31:0] r_acc;
    logic signed [27:0] r_held;
    logic signed [31:0] r_pred, r_n00, r_n01, r_n10, r_n11, r_k0, r_k1, r_innov;
    logic signed [33:0] r_p11;
    logic signed [68:0] r_prod;
    logic signed [31:0] r_o_ra, r_o_rb, r_o_pa, r_o_pb, r_o_ya;
    logic signed [27:0] r_o_yr;

    logic               ax;
    logic signed [33:0] w_q28, w_r28, w_denom;
    logic signed [32:0] w_dt, w_b;
    logic signed [35:0] w_a;
    logic signed [71:0] w_p72, w_rs16, w_rs28;
    logic signed [28:0] w_yr_ext, w_yr_mag;
    logic               w_div_done;
    logic signed [31:0] w_quot;

    assign ax      = i_cmd.axis;
    assign w_q28   = $signed({2'b00, r_pn, 12'd0});
    assign w_r28   = $signed({2'b00, r_rn, 12'd0});
    assign w_dt    = $signed({17'd0, r_dt});
    assign w_denom = 34'(r_n00) + w_r28;
    assign w_p72   = 72'(r_prod);
    assign w_rs16  = rshr(w_p72, 16);
    assign w_rs28  = rshr(w_p72, 28);

    assign w_yr_ext = 29'(i_yaw_rate_in);
    assign w_yr_mag = (w_yr_ext < 0) ? -w_yr_ext : w_yr_ext;

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.mul)
            MUL_PRED: begin
                w_a = 36'(r_rate[ax]) - 36'(r_bias[ax]);
                w_b = w_dt;
            end
            MUL_P11: begin
                w_a = 36'(r_p[ax][3]);
                w_b = w_dt;
            end
            MUL_Q: begin
                w_a = 36'(w_q28);
                w_b = w_dt;
            end
            MUL_S: begin
                w_a = 36'(r_p11) + 36'(w_q28) - 36'(r_p[ax][1]) - 36'(r_p[ax][2]);
                w_b = w_dt;
            end
            MUL_K0I: begin
                w_a = 36'(r_k0);
                w_b = 33'(r_innov);
            end
            MUL_K1I: begin
                w_a = 36'(r_k1);
                w_b = 33'(r_innov);
            end
            MUL_K0N00: begin
                w_a = 36'(r_k0);
                w_b = 33'(r_n00);
            end
            MUL_K0N01: begin
                w_a = 36'(r_k0);
                w_b = 33'(r_n01);
            end
            MUL_K1N00: begin
                w_a = 36'(r_k1);
                w_b = 33'(r_n00);
            end
            MUL_K1N01: begin
                w_a = 36'(r_k1);
                w_b = 33'(r_n01);
            end
            MUL_YAW: begin
                w_a = 36'(r_yr);
                w_b = w_dt;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    kbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (i_cmd.div_sel ? r_n10 : r_n00),
        .i_den   (w_denom[32:0]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_sts.div_done  = w_div_done;
    assign o_sts.denom_pos = (w_denom > 0);

    always_ff @(posedge i_clk) begin
        r_prod <= 69'(w_a) * 69'(w_b);
        if (i_cmd.capture) begin
            r_meas[0] <= i_roll_meas;
            r_meas[1] <= i_pitch_meas;
            r_rate[0] <= i_roll_rate;
            r_rate[1] <= i_pitch_rate;
            r_yr      <= (w_yr_mag < $signed({9'd0, r_db})) ? 28'sd0 : i_yaw_rate_in;
            r_dt      <= i_time_step;
        end
        if (i_cmd.innov_we) begin
            r_innov <= sat32(72'(r_meas[ax]) - 72'(r_pred));
        end
        case (i_cmd.wr)
            WR_PRED:  r_pred <= sat32(72'(r_ang[ax]) + w_rs16);
            WR_P11:   r_p11  <= 34'(w_rs16);
            WR_N11: begin
                r_n11 <= sat32(72'(r_p[ax][3]) + w_rs16);
                r_n01 <= sat32(72'(r_p[ax][1]) - 72'(r_p11));
                r_n10 <= sat32(72'(r_p[ax][2]) - 72'(r_p11));
            end
            WR_N00:   r_n00 <= sat32(72'(r_p[ax][0]) + w_rs16);
            WR_K0:    r_k0  <= w_quot;
            WR_K1:    r_k1  <= w_quot;
            WR_KZERO: begin
                r_k0 <= '0;
                r_k1 <= '0;
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_o_ra <= r_ang[0];
            r_o_rb <= r_bias[0];
            r_o_pa <= r_ang[1];
            r_o_pb <= r_bias[1];
            r_o_ya <= r_acc;
            r_o_yr <= r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pn   <= PROC_NOISE_RST;
            r_rn   <= MEAS_NOISE_RST;
            r_db   <= YAW_DBAND_RST;
            r_acc  <= '0;
            r_held <= '0;
            for (int a = 0; a < 2; a++) begin
                r_ang[a]  <= '0;
                r_bias[a] <= '0;
                for (int j = 0; j < 4; j++) begin
                    r_p[a][j] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROC_NOISE: r_pn <= i_cfg_data;
                    CFG_MEAS_NOISE: r_rn <= i_cfg_data;
                    CFG_YAW_DBAND:  r_db <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.wr)
                WR_ANG:  r_ang[ax]   <= sat32(72'(r_pred) + w_rs28);
                WR_BIAS: r_bias[ax]  <= sat32(72'(r_bias[ax]) + w_rs28);
                WR_P0:   r_p[ax][0]  <= sat32(72'(r_n00) - w_rs28);
                WR_P1:   r_p[ax][1]  <= sat32(72'(r_n01) - w_rs28);
                WR_P2:   r_p[ax][2]  <= sat32(72'(r_n10) - w_rs28);
                WR_P3:   r_p[ax][3]  <= sat32(72'(r_n11) - w_rs28);
                WR_YAW: begin
                    r_acc  <= sat32(72'(r_acc) + w_rs16);
                    r_held <= r_yr;
                end
                default: ;
            endcase
        end
    end

    assign o_roll_angle   = r_o_ra;
    assign o_roll_bias    = r_o_rb;
    assign o_pitch_angle  = r_o_pa;
    assign o_pitch_bias   = r_o_pb;
    assign o_yaw_angle    = r_o_ya;
    assign o_yaw_rate_out = r_o_yr;

endmodule

[design/kbf_ctrl.sv]
// ----------------------------------------------------------------------------
// kbf_ctrl
// Sequencer: per-axis predict, gain division and update, then yaw and output.
// ----------------------------------------------------------------------------
module kbf_ctrl #(
    parameter int FILTERED_AXES = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output kbf_pkg::t_cmd   o_cmd,
    input  kbf_pkg::t_sts   i_sts
);
    import kbf_pkg::*;

    localparam int NAX = (FILTERED_AXES > 2) ? 2 : FILTERED_AXES;

    typedef enum logic [4:0] {
        S_IDLE, S_PRED, S_P11, S_Q, S_S, S_N00,
        S_DIV_K0, S_WAIT_K0, S_DIV_K1, S_WAIT_K1,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_YAW_MUL, S_YAW_WR, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_axis, n_axis;
    logic   r_out_valid;
    logic   w_last_axis;

    assign w_last_axis = (NAX < 2) || r_axis;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_cmd.mul   = MUL_NONE;
        o_cmd.wr    = WR_NONE;
        o_cmd.axis  = r_axis;
        n_state     = r_state;
        n_axis      = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_axis        = 1'b0;
                    n_state       = S_PRED;
                end
            end
            S_PRED: begin
                o_cmd.mul = MUL_PRED;
                n_state   = S_P11;
            end
            S_P11: begin
                o_cmd.mul = MUL_P11;
                o_cmd.wr  = WR_PRED;
                n_state   = S_Q;
            end
            S_Q: begin
                o_cmd.mul = MUL_Q;
                o_cmd.wr  = WR_P11;
                n_state   = S_S;
            end
            S_S: begin
                o_cmd.mul = MUL_S;
                o_cmd.wr  = WR_N11;
                n_state   = S_N00;
            end
            S_N00: begin
                o_cmd.wr = WR_N00;
                n_state  = S_DIV_K0;
            end
            S_DIV_K0: begin
                o_cmd.innov_we = 1'b1;
                if (i_sts.denom_pos) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_WAIT_K0;
                end else begin
                    o_cmd.wr = WR_KZERO;
                    n_state  = S_M1;
                end
            end
            S_WAIT_K0: begin
                if (i_sts.div_done) begin
                    o_cmd.wr = WR_K0;
                    n_state  = S_DIV_K1;
                end
            end
            S_DIV_K1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_state         = S_WAIT_K1;
            end
            S_WAIT_K1: begin
                if (i_sts.div_done) begin
                    o_cmd.wr = WR_K1;
                    n_state  = S_M1;
                end
            end
            S_M1: begin
                o_cmd.mul = MUL_K0I;
                n_state   = S_M2;
            end
            S_M2: begin
                o_cmd.mul = MUL_K1I;
                o_cmd.wr  = WR_ANG;
                n_state   = S_M3;
            end
            S_M3: begin
                o_cmd.mul = MUL_K0N00;
                o_cmd.wr  = WR_BIAS;
                n_state   = S_M4;
            end
            S_M4: begin
                o_cmd.mul = MUL_K0N01;
                o_cmd.wr  = WR_P0;
                n_state   = S_M5;
            end
            S_M5: begin
                o_cmd.mul = MUL_K1N00;
                o_cmd.wr  = WR_P1;
                n_state   = S_M6;
            end
            S_M6: begin
                o_cmd.mul = MUL_K1N01;
                o_cmd.wr  = WR_P2;
                n_state   = S_M7;
            end
            S_M7: begin
                o_cmd.wr = WR_P3;
                if (w_last_axis) begin
                    n_state = S_YAW_MUL;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_PRED;
                end
            end
            S_YAW_MUL: begin
                o_cmd.mul = MUL_YAW;
                n_state   = S_YAW_WR;
            end
            S_YAW_WR: begin
                o_cmd.wr = WR_YAW;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    property p_done_in_wait;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_sts.div_done |-> (r_state == S_WAIT_K0 || r_state == S_WAIT_K1);
    endproperty
    a_done_in_wait: assert property (p_done_in_wait) else $error("stray divide done");

    property p_accept_starts;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_in_valid && !o_in_stall) |=> (r_state == S_PRED && !r_axis);
    endproperty
    a_accept_starts: assert property (p_accept_starts) else $error("bad start");

    property p_valid_from_out;
        @(posedge i_clk) disable iff (!i_rst_n)
            $rose(r_out_valid) |-> $past(r_state) == S_OUT;
    endproperty
    a_valid_from_out: assert property (p_valid_from_out) else $error("stray result");

    property p_no_overwrite;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_valid && i_out_stall) |=> r_out_valid;
    endproperty
    a_no_overwrite: assert property (p_no_overwrite) else $error("result dropped");

endmodule

[design/angle_bias_kalman_filter_top.sv]
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_top
// Roll/pitch angle and gyro-bias Kalman filter with deadbanded yaw integration.
//
// Input channel: i_in_valid / o_in_stall with measured angles, gyro rates and
// time step. A transfer is taken only while the sequencer is idle.
// Output channel: o_out_valid / i_out_stall with filtered angles, biases and
// yaw. One result per input item, in order.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), index 0 process
// noise, 1 measurement noise, 2 yaw deadband; other indices are ignored.
// Write only while the block is idle.
// Each axis runs the 60-step gain divider twice, once per gain; a non-positive
// gain denominator skips both divisions for that axis. Yaw and output follow
// the filtered axes. One item at a time: the next input transfer is taken
// only once the sequencer is back in idle.
// Reset clears the filter state and loads the default register values.
// While the receiver stalls, the held result stays; the next item can be
// taken and computed, and is presented once the held result is transferred.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_top #(
    parameter int FILTERED_AXES = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [24:0]  i_roll_meas,
    input  logic signed [24:0]  i_pitch_meas,
    input  logic signed [27:0]  i_roll_rate,
    input  logic signed [27:0]  i_pitch_rate,
    input  logic signed [27:0]  i_yaw_rate_in,
    input  logic [15:0]         i_time_step,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_roll_angle,
    output logic signed [31:0]  o_roll_bias,
    output logic signed [31:0]  o_pitch_angle,
    output logic signed [31:0]  o_pitch_bias,
    output logic signed [31:0]  o_yaw_angle,
    output logic signed [27:0]  o_yaw_rate_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [19:0]         i_cfg_data
);
    import kbf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    kbf_ctrl #(
        .FILTERED_AXES (FILTERED_AXES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    kbf_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_roll_meas    (i_roll_meas),
        .i_pitch_meas   (i_pitch_meas),
        .i_roll_rate    (i_roll_rate),
        .i_pitch_rate   (i_pitch_rate),
        .i_yaw_rate_in  (i_yaw_rate_in),
        .i_time_step    (i_time_step),
        .o_roll_angle   (o_roll_angle),
        .o_roll_bias    (o_roll_bias),
        .o_pitch_angle  (o_pitch_angle),
        .o_pitch_bias   (o_pitch_bias),
        .o_yaw_angle    (o_yaw_angle),
        .o_yaw_rate_out (o_yaw_rate_out)
    );

endmodule
